// ----- hdl/fcpr_pkg.sv -----
// shared types, constants and the crc-16 byte update for the framed packet receiver
// no dependencies; used by the receive core, the top level and the testbench
package fcpr_pkg;

  // frame parser phases
  typedef enum logic [2:0] {
    PH_HUNT1 = 3'd0,
    PH_HUNT2 = 3'd1,
    PH_SEQ   = 3'd2,
    PH_LEN   = 3'd3,
    PH_DATA  = 3'd4,
    PH_CRCHI = 3'd5,
    PH_CRCLO = 3'd6
  } phase_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_SYNC_FIRST  = 2'd0,
    CFG_SYNC_SECOND = 2'd1,
    CFG_MAX_PAYLOAD = 2'd2,
    CFG_GAP_TIMEOUT = 2'd3
  } cfg_idx_t;

  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] MIN_LEN  = 16'd2;

  localparam logic [7:0]  SYNC_FIRST_RST  = 8'h55;
  localparam logic [7:0]  SYNC_SECOND_RST = 8'hAA;
  localparam logic [15:0] MAX_PAYLOAD_RST = 16'd98;
  localparam logic [15:0] GAP_TIMEOUT_RST = 16'd200;

  // configuration as seen by the core
  typedef struct packed {
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
    logic [15:0] max_payload;
    logic [15:0] gap_timeout_ms;
  } cfg_t;

  // receiver state carried from byte to byte
  typedef struct packed {
    phase_t      phase;
    logic [15:0] frame_length;
    logic        length_bytes_seen;
    logic [15:0] bytes_counted;
    logic [15:0] running_crc;
    logic [7:0]  crc_high_byte;
    logic [31:0] last_time_ms;
    logic        time_seen;
  } rx_state_t;

  // one input item
  typedef struct packed {
    logic        action;
    logic [7:0]  byte_value;
    logic [31:0] now_ms;
  } rx_item_t;

  // one result item
  typedef struct packed {
    logic        frame_ok;
    logic        crc_error;
    logic        length_error;
    logic        timeout_drop;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
  } rx_result_t;

  // crc-16, msb first, no reflection, eight shift steps per byte
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] crc;
    crc = crc_in ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (crc[15]) begin
        crc = {crc[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        crc = {crc[14:0], 1'b0};
      end
    end
    return crc;
  endfunction

endpackage

// ----- hdl/fcpr_if.sv -----
// valid/ready channel interfaces for the framed packet receiver
// depends on nothing but plain logic types
interface fcpr_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [7:0]  byte_value;
  logic [31:0] now_ms;

  modport source (output valid, output action, output byte_value, output now_ms,
                  input ready);
  modport sink   (input valid, input action, input byte_value, input now_ms,
                  output ready);
endinterface

interface fcpr_out_if;
  logic        valid;
  logic        ready;
  logic        frame_ok;
  logic        crc_error;
  logic        length_error;
  logic        timeout_drop;
  logic        payload_valid;
  logic [7:0]  payload_byte;
  logic [15:0] payload_index;

  modport source (output valid, output frame_ok, output crc_error, output length_error,
                  output timeout_drop, output payload_valid, output payload_byte,
                  output payload_index, input ready);
  modport sink   (input valid, input frame_ok, input crc_error, input length_error,
                  input timeout_drop, input payload_valid, input payload_byte,
                  input payload_index, output ready);
endinterface

// ----- hdl/fcpr_rx_core.sv -----
// next-state and result logic for one received byte or clear command
// depends on fcpr_pkg (state, item, result and config types, crc update)
module fcpr_rx_core (
  input  fcpr_pkg::cfg_t       cfg,
  input  fcpr_pkg::rx_state_t  state_cur,
  input  fcpr_pkg::rx_item_t   item,
  output fcpr_pkg::rx_state_t  state_nxt,
  output fcpr_pkg::rx_result_t result
);

  logic [31:0] gap;
  logic        time_bad;
  logic [15:0] len_full;
  logic [15:0] count_inc;

  // time went backwards or the byte gap is too long
  assign gap      = item.now_ms - state_cur.last_time_ms;
  assign time_bad = state_cur.time_seen &&
                    ((item.now_ms < state_cur.last_time_ms) ||
                     (gap > {16'h0000, cfg.gap_timeout_ms}));

  assign len_full  = {item.byte_value, state_cur.frame_length[7:0]};
  assign count_inc = state_cur.bytes_counted + 16'd1;

  // frame parser
  always_comb begin
    state_nxt = state_cur;
    result    = '0;
    if (item.action) begin
      state_nxt.phase             = fcpr_pkg::PH_HUNT1;
      state_nxt.frame_length      = '0;
      state_nxt.length_bytes_seen = 1'b0;
      state_nxt.bytes_counted     = '0;
      state_nxt.time_seen         = 1'b0;
    end else begin
      if (time_bad) begin
        result.timeout_drop         = (state_cur.phase != fcpr_pkg::PH_HUNT1);
        state_nxt.phase             = fcpr_pkg::PH_HUNT1;
        state_nxt.frame_length      = '0;
        state_nxt.length_bytes_seen = 1'b0;
        state_nxt.bytes_counted     = '0;
      end
      state_nxt.last_time_ms = item.now_ms;
      state_nxt.time_seen    = 1'b1;

      case (state_nxt.phase)
        fcpr_pkg::PH_HUNT1: begin
          if (item.byte_value == cfg.sync_first) begin
            state_nxt.phase = fcpr_pkg::PH_HUNT2;
          end
        end
        fcpr_pkg::PH_HUNT2: begin
          if (item.byte_value == cfg.sync_second) begin
            state_nxt.phase = fcpr_pkg::PH_SEQ;
          end else if (item.byte_value != cfg.sync_first) begin
            state_nxt.phase = fcpr_pkg::PH_HUNT1;
          end
        end
        fcpr_pkg::PH_SEQ: begin
          state_nxt.frame_length      = '0;
          state_nxt.length_bytes_seen = 1'b0;
          state_nxt.phase             = fcpr_pkg::PH_LEN;
        end
        fcpr_pkg::PH_LEN: begin
          if (!state_cur.length_bytes_seen) begin
            state_nxt.frame_length      = {8'h00, item.byte_value};
            state_nxt.length_bytes_seen = 1'b1;
          end else begin
            state_nxt.length_bytes_seen = 1'b0;
            if ((len_full < fcpr_pkg::MIN_LEN) || (len_full > cfg.max_payload)) begin
              // bad length drops the frame and forgets the time
              result.length_error     = 1'b1;
              state_nxt.phase         = fcpr_pkg::PH_HUNT1;
              state_nxt.frame_length  = '0;
              state_nxt.bytes_counted = '0;
              state_nxt.time_seen     = 1'b0;
            end else begin
              state_nxt.frame_length  = len_full;
              state_nxt.bytes_counted = '0;
              state_nxt.running_crc   = '0;
              state_nxt.phase         = fcpr_pkg::PH_DATA;
            end
          end
        end
        fcpr_pkg::PH_DATA: begin
          result.payload_valid    = 1'b1;
          result.payload_byte     = item.byte_value;
          result.payload_index    = state_cur.bytes_counted;
          state_nxt.running_crc   = fcpr_pkg::crc16_byte(state_cur.running_crc,
                                                         item.byte_value);
          state_nxt.bytes_counted = count_inc;
          if (count_inc == state_cur.frame_length) begin
            state_nxt.phase = fcpr_pkg::PH_CRCHI;
          end
        end
        fcpr_pkg::PH_CRCHI: begin
          state_nxt.crc_high_byte = item.byte_value;
          state_nxt.phase         = fcpr_pkg::PH_CRCLO;
        end
        fcpr_pkg::PH_CRCLO: begin
          if ({state_cur.crc_high_byte, item.byte_value} == state_cur.running_crc) begin
            result.frame_ok = 1'b1;
          end else begin
            result.crc_error = 1'b1;
          end
          state_nxt.phase = fcpr_pkg::PH_HUNT1;
        end
        default: begin
          state_nxt.phase = fcpr_pkg::PH_HUNT1;
        end
      endcase
    end
  end

endmodule

// ----- hdl/framed_crc16_packet_receiver.sv -----
// framed serial packet receiver with on-the-fly crc-16 check
// depends on fcpr_pkg, fcpr_if.sv (channel interfaces) and fcpr_rx_core
//
// Usage:
//   in_ch carries one item per transfer: a received byte with its millisecond
//   timestamp, or a clear command (action = 1). out_ch carries exactly one
//   result per input item, in order: frame_ok / crc_error on the last trailer
//   byte, length_error on a rejected length, timeout_drop when a partial frame
//   was dropped, and the payload byte with its index while in the payload.
//   cfg_we/cfg_index/cfg_data write the sync bytes, maximum length and gap
//   timeout; write them only while no item is in flight.
//   Each input item is held in the input register; the parser and crc
//   update then feed the result register, from which out_ch is driven.
//   Throughput is one item per cycle while out_ch does not stall; the
//   byte-wide crc update and the state step are both combinational between
//   the two registers.
//   When out_ch stalls, the result register and then the input register hold,
//   and in_ch.ready drops once both are full; nothing is lost or repeated.
//   Synchronous active-low reset empties both registers, puts the parser in
//   the hunt for the first sync byte and restores the register defaults.
module framed_crc16_packet_receiver (
  input  logic                            clk,
  input  logic                            rst_n,
  fcpr_in_if.sink                         in_ch,
  fcpr_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [fcpr_pkg::CFG_DATA_W-1:0] cfg_data
);

  fcpr_pkg::cfg_t       cfg_r;
  fcpr_pkg::rx_state_t  state_r;
  fcpr_pkg::rx_state_t  state_nxt;
  fcpr_pkg::rx_item_t   item_r;
  fcpr_pkg::rx_result_t result_nxt;
  fcpr_pkg::rx_result_t result_r;
  logic                 item_valid_r;
  logic                 out_valid_r;
  logic                 item_move;

  // pipeline handshake
  assign item_move   = item_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !item_valid_r || item_move;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_first     <= fcpr_pkg::SYNC_FIRST_RST;
      cfg_r.sync_second    <= fcpr_pkg::SYNC_SECOND_RST;
      cfg_r.max_payload    <= fcpr_pkg::MAX_PAYLOAD_RST;
      cfg_r.gap_timeout_ms <= fcpr_pkg::GAP_TIMEOUT_RST;
    end else if (cfg_we) begin
      case (fcpr_pkg::cfg_idx_t'(cfg_index))
        fcpr_pkg::CFG_SYNC_FIRST:  cfg_r.sync_first     <= cfg_data[7:0];
        fcpr_pkg::CFG_SYNC_SECOND: cfg_r.sync_second    <= cfg_data[7:0];
        fcpr_pkg::CFG_MAX_PAYLOAD: cfg_r.max_payload    <= cfg_data;
        fcpr_pkg::CFG_GAP_TIMEOUT: cfg_r.gap_timeout_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      item_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      item_r.action     <= in_ch.action;
      item_r.byte_value <= in_ch.byte_value;
      item_r.now_ms     <= in_ch.now_ms;
    end
  end

  // parser and crc step
  fcpr_rx_core u_core (
    .cfg       (cfg_r),
    .state_cur (state_r),
    .item      (item_r),
    .state_nxt (state_nxt),
    .result    (result_nxt)
  );

  // receiver state advances as each item moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase             <= fcpr_pkg::PH_HUNT1;
      state_r.frame_length      <= '0;
      state_r.length_bytes_seen <= 1'b0;
      state_r.bytes_counted     <= '0;
      state_r.running_crc       <= '0;
      state_r.crc_high_byte     <= '0;
      state_r.last_time_ms      <= '0;
      state_r.time_seen         <= 1'b0;
    end else if (item_move) begin
      state_r <= state_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (item_move) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_move) begin
      result_r <= result_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.frame_ok      = result_r.frame_ok;
  assign out_ch.crc_error     = result_r.crc_error;
  assign out_ch.length_error  = result_r.length_error;
  assign out_ch.timeout_drop  = result_r.timeout_drop;
  assign out_ch.payload_valid = result_r.payload_valid;
  assign out_ch.payload_byte  = result_r.payload_byte;
  assign out_ch.payload_index = result_r.payload_index;

  // checks on the pipeline and the result flags
  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && !item_move |=> $stable(state_r))
    else $error("receiver state changed without an item moving");

  a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
    item_valid_r && !item_move |=> item_valid_r && $stable(item_r))
    else $error("input register lost or changed a waiting item");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r && $stable(result_r))
    else $error("stalled result was overwritten");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot0({result_r.frame_ok, result_r.crc_error,
                              result_r.length_error, result_r.payload_valid}))
    else $error("conflicting result flags");

endmodule

// ----- tb/sv/tb_framed_crc16_packet_receiver.sv -----
// self-checking testbench for framed_crc16_packet_receiver: directed frames, then random traffic
// depends on fcpr_pkg, the fcpr_in_if / fcpr_out_if channel interfaces and the receiver top level
module tb_framed_crc16_packet_receiver;

  localparam int CYCLE_LIMIT = 500000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  fcpr_in_if  in_ch();
  fcpr_out_if out_ch();

  framed_crc16_packet_receiver DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // register copy held by the predictor
  fcpr_pkg::cfg_t rx_cfg = '{sync_first: fcpr_pkg::SYNC_FIRST_RST,
                             sync_second: fcpr_pkg::SYNC_SECOND_RST,
                             max_payload: fcpr_pkg::MAX_PAYLOAD_RST,
                             gap_timeout_ms: fcpr_pkg::GAP_TIMEOUT_RST};

  // predicted parser state
  fcpr_pkg::phase_t rx_phase = fcpr_pkg::PH_HUNT1;
  logic [15:0] rx_len      = '0;
  logic        rx_len_half = 1'b0;
  logic [15:0] rx_count    = '0;
  logic [15:0] rx_crc      = '0;
  logic [7:0]  rx_crc_hi   = '0;
  logic [31:0] rx_last_ms  = '0;
  logic        rx_time_ok  = 1'b0;

  fcpr_pkg::rx_result_t pending_results[$];
  int          mismatch_count = 0;
  int          cycle_count    = 0;
  int          sent_items     = 0;
  bit          idle_on        = 1'b1;
  logic [31:0] t_now          = '0;

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // crc-16 xmodem, one data bit at a time
  function automatic logic [15:0] crc16_update(input logic [15:0] c, input logic [7:0] d);
    logic fb;
    for (int k = 7; k >= 0; k--) begin
      fb = c[15] ^ d[k];
      c  = {c[14:0], 1'b0};
      if (fb) c = c ^ fcpr_pkg::CRC_POLY;
    end
    return c;
  endfunction

  function automatic void clear_parser();
    rx_phase    = fcpr_pkg::PH_HUNT1;
    rx_len      = '0;
    rx_len_half = 1'b0;
    rx_count    = '0;
    rx_time_ok  = 1'b0;
  endfunction

  // expected result of one item, advancing the predicted state
  function automatic fcpr_pkg::rx_result_t deframe_step(input fcpr_pkg::rx_item_t it);
    fcpr_pkg::rx_result_t r;
    logic [7:0] b;
    r = '0;
    b = it.byte_value;
    if (it.action) begin
      clear_parser();
    end else begin
      // stale or backwards timestamp drops any partial frame
      if (rx_time_ok && (it.now_ms < rx_last_ms ||
          (it.now_ms - rx_last_ms) > {16'h0000, rx_cfg.gap_timeout_ms})) begin
        r.timeout_drop = (rx_phase != fcpr_pkg::PH_HUNT1);
        clear_parser();
      end
      rx_last_ms = it.now_ms;
      rx_time_ok = 1'b1;
      case (rx_phase)
        fcpr_pkg::PH_HUNT1: begin
          if (b == rx_cfg.sync_first) rx_phase = fcpr_pkg::PH_HUNT2;
        end
        fcpr_pkg::PH_HUNT2: begin
          if (b == rx_cfg.sync_second)     rx_phase = fcpr_pkg::PH_SEQ;
          else if (b == rx_cfg.sync_first) rx_phase = fcpr_pkg::PH_HUNT2;
          else                             rx_phase = fcpr_pkg::PH_HUNT1;
        end
        fcpr_pkg::PH_SEQ: begin
          rx_len      = '0;
          rx_len_half = 1'b0;
          rx_phase    = fcpr_pkg::PH_LEN;
        end
        fcpr_pkg::PH_LEN: begin
          if (!rx_len_half) begin
            rx_len      = {8'h00, b};
            rx_len_half = 1'b1;
          end else begin
            rx_len      = {b, rx_len[7:0]};
            rx_len_half = 1'b0;
            if (rx_len < fcpr_pkg::MIN_LEN || rx_len > rx_cfg.max_payload) begin
              r.length_error = 1'b1;
              clear_parser();
            end else begin
              rx_count = '0;
              rx_crc   = '0;
              rx_phase = fcpr_pkg::PH_DATA;
            end
          end
        end
        fcpr_pkg::PH_DATA: begin
          r.payload_valid = 1'b1;
          r.payload_byte  = b;
          r.payload_index = rx_count;
          rx_crc   = crc16_update(rx_crc, b);
          rx_count = rx_count + 16'd1;
          if (rx_count == rx_len) rx_phase = fcpr_pkg::PH_CRCHI;
        end
        fcpr_pkg::PH_CRCHI: begin
          rx_crc_hi = b;
          rx_phase  = fcpr_pkg::PH_CRCLO;
        end
        fcpr_pkg::PH_CRCLO: begin
          if ({rx_crc_hi, b} == rx_crc) r.frame_ok  = 1'b1;
          else                          r.crc_error = 1'b1;
          rx_phase = fcpr_pkg::PH_HUNT1;
        end
        default: rx_phase = fcpr_pkg::PH_HUNT1;
      endcase
    end
    return r;
  endfunction

  function automatic int draw_wait();
    return idle_on ? int'($urandom_range(0, 6)) : 0;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("cycle %0d: mismatch on %s, got %0h expected %0h", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  // one input transfer, expectation queued at acceptance
  task automatic send_item(input logic act, input logic [7:0] b, input logic [31:0] t);
    fcpr_pkg::rx_item_t it;
    int       gap;
    it.action     = act;
    it.byte_value = b;
    it.now_ms     = t;
    gap = draw_wait();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.action     <= act;
    in_ch.byte_value <= b;
    in_ch.now_ms     <= t;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(deframe_step(it));
    sent_items++;
    if ($urandom_range(0, 199) == 0) idle_on = !idle_on;
  endtask

  task automatic send_clear();
    send_item(1'b1, 8'($urandom_range(0, 255)), $urandom());
  endtask

  // directed byte, time moved on by dt
  task automatic send_at(input logic [7:0] b, input logic [31:0] dt);
    t_now = t_now + dt;
    send_item(1'b0, b, t_now);
  endtask

  // random time step: mostly in range, sometimes on the limit, over it or jumping
  task automatic advance_ms();
    int unsigned pick;
    logic [31:0] g;
    g    = {16'h0000, rx_cfg.gap_timeout_ms};
    pick = $urandom_range(0, 999);
    if (pick < 8)       t_now = $urandom();
    else if (pick < 16) t_now = t_now + g + 32'd1 + $urandom_range(0, 1000);
    else if (pick < 60) t_now = t_now + g;
    else                t_now = t_now + $urandom_range(0, (g < 20) ? g : 20);
  endtask

  task automatic send_rand_byte(input logic [7:0] b);
    if ($urandom_range(0, 149) == 0) send_clear();
    advance_ms();
    send_item(1'b0, b, t_now);
  endtask

  // mostly well-formed frame with random content; sometimes broken
  task automatic send_random_frame();
    int unsigned pick, n, cut;
    logic [15:0] len, cap, crc;
    logic [7:0]  b;
    if ($urandom_range(0, 7) == 0)
      repeat ($urandom_range(1, 3)) send_rand_byte(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 29) == 0) send_clear();
    send_rand_byte(rx_cfg.sync_first);
    if ($urandom_range(0, 4) == 0) send_rand_byte(rx_cfg.sync_first);
    if ($urandom_range(0, 24) == 0) send_rand_byte(8'($urandom_range(0, 255)));
    else                            send_rand_byte(rx_cfg.sync_second);
    send_rand_byte(8'($urandom_range(0, 255)));
    cap = (rx_cfg.max_payload < 16'd12) ? rx_cfg.max_payload : 16'd12;
    if (cap < 16'd2) cap = 16'd2;
    pick = $urandom_range(0, 39);
    case (pick)
      0, 1:    len = 16'($urandom_range(0, 1));
      2:       len = (rx_cfg.max_payload == 16'hFFFF) ? 16'($urandom_range(256, 300))
                                                      : 16'($urandom_range(0, 65535));
      3, 4:    len = (rx_cfg.max_payload == 16'hFFFF) ? 16'd0 : rx_cfg.max_payload + 16'd1;
      5:       len = (rx_cfg.max_payload > 16'd300) ? 16'd300 : rx_cfg.max_payload;
      default: len = 16'($urandom_range(2, cap));
    endcase
    send_rand_byte(len[7:0]);
    send_rand_byte(len[15:8]);
    if (len < fcpr_pkg::MIN_LEN || len > rx_cfg.max_payload) return;
    cut = ($urandom_range(0, 19) == 0) ? $urandom_range(0, len - 1) : len;
    crc = '0;
    for (n = 0; n < len; n++) begin
      if (n == cut) return;
      b   = 8'($urandom_range(0, 255));
      crc = crc16_update(crc, b);
      send_rand_byte(b);
    end
    if ($urandom_range(0, 5) == 0) crc = crc ^ 16'($urandom_range(1, 65535));
    send_rand_byte(crc[15:8]);
    send_rand_byte(crc[7:0]);
  endtask

  // wait until every result is back and the pipeline has emptied
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // all four registers, one per cycle
  task automatic load_config(input logic [7:0] sf, input logic [7:0] ss,
                             input logic [15:0] maxp, input logic [15:0] gap);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= fcpr_pkg::CFG_SYNC_FIRST;
    cfg_data  <= {8'h00, sf};
    @(posedge clk);
    cfg_index <= fcpr_pkg::CFG_SYNC_SECOND;
    cfg_data  <= {8'h00, ss};
    @(posedge clk);
    cfg_index <= fcpr_pkg::CFG_MAX_PAYLOAD;
    cfg_data  <= maxp;
    @(posedge clk);
    cfg_index <= fcpr_pkg::CFG_GAP_TIMEOUT;
    cfg_data  <= gap;
    @(posedge clk);
    cfg_we <= 1'b0;
    rx_cfg.sync_first     = sf;
    rx_cfg.sync_second    = ss;
    rx_cfg.max_payload    = maxp;
    rx_cfg.gap_timeout_ms = gap;
  endtask

  // clear command, then a good frame behind a repeated first sync byte
  task automatic test_clear_and_sync();
    logic [15:0] crc;
    send_item(1'b1, 8'hFF, 32'hFFFF_FFFF);
    crc = crc16_update(crc16_update(16'h0000, 8'hFF), 8'h00);
    send_at(8'h55, 32'd1);
    send_at(8'h55, 32'd1);
    send_at(8'hAA, 32'd1);
    send_at(8'h00, 32'd1);
    send_at(8'h02, 32'd1);
    send_at(8'h00, 32'd1);
    send_at(8'hFF, 32'd1);
    send_at(8'h00, 32'd1);
    send_at(crc[15:8], 32'd1);
    send_at(crc[7:0], 32'd1);
  endtask

  // lengths just below the minimum and just above the maximum
  task automatic test_length_limits();
    send_at(8'h55, 32'd1);
    send_at(8'hAA, 32'd1);
    send_at(8'hFF, 32'd1);
    send_at(8'h01, 32'd1);
    send_at(8'h00, 32'd1);
    send_at(8'h55, 32'd1);
    send_at(8'hAA, 32'd1);
    send_at(8'h7E, 32'd1);
    send_at(fcpr_pkg::MAX_PAYLOAD_RST[7:0] + 8'd1, 32'd1);
    send_at(fcpr_pkg::MAX_PAYLOAD_RST[15:8], 32'd1);
  endtask

  // gap over the limit, gap on the limit, clear mid-frame, time going backwards
  task automatic test_time_checks();
    send_at(8'h55, 32'd1);
    send_at(8'hAA, {16'h0000, fcpr_pkg::GAP_TIMEOUT_RST} + 32'd1);
    send_at(8'h55, {16'h0000, fcpr_pkg::GAP_TIMEOUT_RST});
    send_at(8'hAA, {16'h0000, fcpr_pkg::GAP_TIMEOUT_RST});
    send_clear();
    send_at(8'h55, 32'd0);
    send_at(8'hAA, 32'hFFFF_FFFD);
    send_at(8'h55, 32'd1);
  endtask

  task automatic run_traffic(input logic [7:0] sf, input logic [7:0] ss,
                             input logic [15:0] maxp, input logic [15:0] gap, input int n);
    int stop_at;
    load_config(sf, ss, maxp, gap);
    stop_at = sent_items + n;
    while (sent_items < stop_at) send_random_frame();
  endtask

  // random traffic over several register settings, extremes included
  task automatic test_random_traffic();
    logic [7:0] s;
    run_traffic(fcpr_pkg::SYNC_FIRST_RST, fcpr_pkg::SYNC_SECOND_RST,
                fcpr_pkg::MAX_PAYLOAD_RST, fcpr_pkg::GAP_TIMEOUT_RST, 350);
    run_traffic(8'h00, 8'hFF, 16'd2, 16'd0, 350);
    t_now = 32'hFFFF_F000;
    run_traffic(8'hFF, 8'h00, 16'hFFFF, 16'hFFFF, 350);
    s = 8'($urandom_range(0, 255));
    run_traffic(s, s, 16'($urandom_range(2, 40)), 16'($urandom_range(1, 500)), 350);
    run_traffic(8'h7E, 8'h81, 16'd1, 16'hFFFF, 150);
    run_traffic(fcpr_pkg::SYNC_FIRST_RST, fcpr_pkg::SYNC_SECOND_RST,
                fcpr_pkg::MAX_PAYLOAD_RST, fcpr_pkg::GAP_TIMEOUT_RST, 450);
  endtask

  // stimulus and end of run
  initial begin : stimulus
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.action     <= 1'b0;
    in_ch.byte_value <= '0;
    in_ch.now_ms     <= '0;
    cfg_we           <= 1'b0;
    cfg_index        <= fcpr_pkg::CFG_SYNC_FIRST;
    cfg_data         <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_clear_and_sync();
    test_length_limits();
    test_time_checks();
    test_random_traffic();
    settle();
    repeat (6) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // result side: random stalls, each transfer checked against the oldest expectation
  initial begin : result_checker
    int         stall;
    fcpr_pkg::rx_result_t got, want;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got.frame_ok      = out_ch.frame_ok;
      got.crc_error     = out_ch.crc_error;
      got.length_error  = out_ch.length_error;
      got.timeout_drop  = out_ch.timeout_drop;
      got.payload_valid = out_ch.payload_valid;
      got.payload_byte  = out_ch.payload_byte;
      got.payload_index = out_ch.payload_index;
      if (pending_results.size() == 0) begin
        flag_mismatch("result with nothing expected", 32'(got), 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (got.frame_ok !== want.frame_ok)
          flag_mismatch("frame_ok", 32'(got.frame_ok), 32'(want.frame_ok));
        if (got.crc_error !== want.crc_error)
          flag_mismatch("crc_error", 32'(got.crc_error), 32'(want.crc_error));
        if (got.length_error !== want.length_error)
          flag_mismatch("length_error", 32'(got.length_error), 32'(want.length_error));
        if (got.timeout_drop !== want.timeout_drop)
          flag_mismatch("timeout_drop", 32'(got.timeout_drop), 32'(want.timeout_drop));
        if (got.payload_valid !== want.payload_valid)
          flag_mismatch("payload_valid", 32'(got.payload_valid), 32'(want.payload_valid));
        if (got.payload_byte !== want.payload_byte)
          flag_mismatch("payload_byte", 32'(got.payload_byte), 32'(want.payload_byte));
        if (got.payload_index !== want.payload_index)
          flag_mismatch("payload_index", 32'(got.payload_index), 32'(want.payload_index));
      end
    end
  end

endmodule
